### hw/rtl/gbfi_pkg.sv
// ----------------------------------------------------------------------------
// gbfi_pkg
// Shared constants and types for the bounded gamma face interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gbfi_pkg;

    // Default cell value width (Q16.16)
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Number of fractional bits of the normalized variable
    localparam int PHI_BITS = 16;

    // Number of bits of the blend weight (always below one half)
    localparam int WEIGHT_BITS = 15;

    // Width and reset value of the blend threshold register (Q0.16)
    localparam int BETA_WIDTH = 16;
    localparam logic [BETA_WIDTH-1:0] BETA_RESET = 16'h8000;

    // Number of cell values in one request
    localparam int NUM_FIELDS = 5;

    // Per-item decision flags carried down the pipeline
    typedef struct packed {
        logic take;   // phi strictly inside (0,1): move away from C
        logic cdneg;  // D below C
        logic ge;     // phi at or above beta: central mean
    } flags_t;

endpackage

`default_nettype wire

### hw/rtl/bounded_gamma_face_interpolator.sv
// An accepted request reaches its result on m_tdata through
// 1 front stage, 16 + 15 divider stages and 2 back-end stages.
// Throughput: one request per cycle while the result side does not stall; the
// 16-stage and 15-stage divider pipelines each retire one quotient bit per stage.
// A stall on the result side holds every stage in place.
// Reset clears all valid bits and loads blend_threshold with 0.5.
// ----------------------------------------------------------------------------
// bounded_gamma_face_interpolator
// Gamma-scheme bounded face value from four cells and the face speed.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_gamma_face_interpolator #(
    parameter int VALUE_WIDTH = gbfi_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // blend_threshold write
    input  wire logic                                     cfg_we,
    input  wire logic [gbfi_pkg::BETA_WIDTH-1:0]          cfg_wdata,
    // Request channel
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // face_speed, value_minus_one, value_here, value_plus_one, value_plus_two
    input  wire logic [((gbfi_pkg::NUM_FIELDS*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // Result channel
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // face_value
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]              m_tdata
);

    localparam int W     = VALUE_WIDTH;
    localparam int PB    = gbfi_pkg::PHI_BITS;
    localparam int WB    = gbfi_pkg::WEIGHT_BITS;
    localparam int BW    = gbfi_pkg::BETA_WIDTH;
    localparam int FW    = $bits(gbfi_pkg::flags_t);
    localparam int SIDEW = 2*W + FW;
    localparam int OUTW  = ((W+7)/8)*8;

    logic [BW-1:0] beta_reg;
    logic          adv;

    logic             f_valid;
    logic [W-1:0]     f_cen, f_cdmag, f_nmag, f_dmag;
    gbfi_pkg::flags_t f_flags;

    logic             d1_valid;
    logic [PB-1:0]    d1_phi;
    logic [SIDEW-1:0] d1_side;
    gbfi_pkg::flags_t d1_flags, d2in_flags;
    logic             phi_ge;

    logic             d2_valid;
    logic [WB-1:0]    d2_w;
    logic [SIDEW-1:0] d2_side;
    gbfi_pkg::flags_t d2_flags;

    logic             b_valid;
    logic [W-1:0]     b_value;

    // Advance the whole pipeline unless the result waits
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Blend threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= gbfi_pkg::BETA_RESET;
        end else if (cfg_we) begin
            beta_reg <= cfg_wdata;
        end
    end

    gbfi_front #(.VALUE_WIDTH(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata[gbfi_pkg::NUM_FIELDS*W-1:0]),
        .out_valid (f_valid),
        .cen       (f_cen),
        .cdmag     (f_cdmag),
        .nmag      (f_nmag),
        .dmag      (f_dmag),
        .flags     (f_flags)
    );

    // phi = |C-U| / |D-U| in Q0.16
    gbfi_div #(.NUM_WIDTH(W), .STEPS(PB), .SIDE_WIDTH(SIDEW)) u_phi_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (f_valid),
        .num       (f_nmag),
        .den       (f_dmag),
        .side_in   ({f_cen, f_cdmag, f_flags}),
        .out_valid (d1_valid),
        .quo       (d1_phi),
        .side_out  (d1_side)
    );

    // Central mean from beta up; a zero beta always lands here
    assign d1_flags = gbfi_pkg::flags_t'(d1_side[FW-1:0]);
    assign phi_ge   = d1_phi >= beta_reg;

    always_comb begin
        d2in_flags    = d1_flags;
        d2in_flags.ge = phi_ge;
    end

    // w = phi / (2 beta) in Q0.16
    gbfi_div #(.NUM_WIDTH(PB), .STEPS(WB), .SIDE_WIDTH(SIDEW)) u_w_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d1_valid),
        .num       (phi_ge ? '0 : d1_phi),
        .den       (beta_reg),
        .side_in   ({d1_side[SIDEW-1:FW], d2in_flags}),
        .out_valid (d2_valid),
        .quo       (d2_w),
        .side_out  (d2_side)
    );

    assign d2_flags = gbfi_pkg::flags_t'(d2_side[FW-1:0]);

    gbfi_back #(.VALUE_WIDTH(W)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (d2_valid),
        .weight     (d2_w),
        .cen        (d2_side[SIDEW-1 -: W]),
        .cdmag      (d2_side[FW +: W]),
        .flags      (d2_flags),
        .out_valid  (b_valid),
        .face_value (b_value)
    );

    assign m_tvalid = b_valid;
    assign m_tdata  = OUTW'(b_value);

endmodule

`default_nettype wire

### hw/rtl/gbfi_front.sv
// ----------------------------------------------------------------------------
// gbfi_front
// Upwind/central/downwind selection and exact difference magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfi_front #(
    parameter int VALUE_WIDTH = gbfi_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire logic [gbfi_pkg::NUM_FIELDS*VALUE_WIDTH-1:0] in_data,
    output logic                                        out_valid,
    output logic [VALUE_WIDTH-1:0]                      cen,
    output logic [VALUE_WIDTH-1:0]                      cdmag,
    output logic [VALUE_WIDTH-1:0]                      nmag,
    output logic [VALUE_WIDTH-1:0]                      dmag,
    output gbfi_pkg::flags_t                            flags
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0] spd, vm1, v0, vp1, vp2;
    logic [W-1:0] up, c, dn;
    logic [W:0]   n_diff, d_diff, cd_diff;
    logic [W-1:0] n_mag, d_mag, cd_mag;
    logic         take;

    logic             valid_reg;
    logic [W-1:0]     cen_reg, cdmag_reg, nmag_reg, dmag_reg;
    gbfi_pkg::flags_t flags_reg;
    gbfi_pkg::flags_t flags_next;

    assign spd = in_data[0*W +: W];
    assign vm1 = in_data[1*W +: W];
    assign v0  = in_data[2*W +: W];
    assign vp1 = in_data[3*W +: W];
    assign vp2 = in_data[4*W +: W];

    // Pick cells by the sign of the speed
    always_comb begin
        if (!spd[W-1]) begin
            up = vm1;
            c  = v0;
            dn = vp1;
        end else begin
            up = vp2;
            c  = vp1;
            dn = v0;
        end
    end

    // Exact differences, one extra bit so nothing wraps
    assign n_diff  = {c[W-1], c}   - {up[W-1], up};
    assign d_diff  = {dn[W-1], dn} - {up[W-1], up};
    assign cd_diff = {dn[W-1], dn} - {c[W-1], c};

    assign n_mag  = n_diff[W]  ? W'(-n_diff)  : n_diff[W-1:0];
    assign d_mag  = d_diff[W]  ? W'(-d_diff)  : d_diff[W-1:0];
    assign cd_mag = cd_diff[W] ? W'(-cd_diff) : cd_diff[W-1:0];

    // Phi strictly inside (0,1)
    assign take = (d_mag != '0) && (n_mag != '0) && (n_diff[W] == d_diff[W])
                  && (n_mag < d_mag);

    always_comb begin
        flags_next.take  = take;
        flags_next.cdneg = cd_diff[W];
        flags_next.ge    = 1'b0;
    end

    // Clear valid under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (en) begin
            cen_reg   <= c;
            cdmag_reg <= cd_mag;
            nmag_reg  <= n_mag;
            dmag_reg  <= d_mag;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign cen       = cen_reg;
    assign cdmag     = cdmag_reg;
    assign nmag      = nmag_reg;
    assign dmag      = dmag_reg;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

### hw/rtl/gbfi_div.sv
// ----------------------------------------------------------------------------
// gbfi_div
// Pipelined restoring fraction divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfi_div #(
    parameter int NUM_WIDTH  = 32,
    parameter int STEPS      = 16,
    parameter int SIDE_WIDTH = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [NUM_WIDTH-1:0]  num,
    input  wire logic [NUM_WIDTH-1:0]  den,
    input  wire logic [SIDE_WIDTH-1:0] side_in,
    output logic                       out_valid,
    output logic [STEPS-1:0]           quo,
    output logic [SIDE_WIDTH-1:0]      side_out
);

    logic [NUM_WIDTH-1:0]  rem_w  [0:STEPS];
    logic [NUM_WIDTH-1:0]  den_w  [0:STEPS];
    logic [STEPS-1:0]      quo_w  [0:STEPS];
    logic [SIDE_WIDTH-1:0] side_w [0:STEPS];
    logic                  val_w  [0:STEPS];

    assign rem_w[0]  = num;
    assign den_w[0]  = den;
    assign quo_w[0]  = '0;
    assign side_w[0] = side_in;
    assign val_w[0]  = in_valid;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [NUM_WIDTH:0]    trial;
        logic                  fits;
        logic [NUM_WIDTH-1:0]  rem_next;
        logic [STEPS-1:0]      quo_next;
        logic                  valid_reg;
        logic [NUM_WIDTH-1:0]  rem_reg, den_reg;
        logic [STEPS-1:0]      quo_reg;
        logic [SIDE_WIDTH-1:0] side_reg;

        // Shift in one bit and try to subtract the divisor
        assign trial    = {rem_w[k], 1'b0};
        assign fits     = trial >= {1'b0, den_w[k]};
        assign rem_next = fits ? NUM_WIDTH'(trial - {1'b0, den_w[k]})
                               : trial[NUM_WIDTH-1:0];
        assign quo_next = {quo_w[k][STEPS-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (en) begin
                valid_reg <= val_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= rem_next;
                den_reg  <= den_w[k];
                quo_reg  <= quo_next;
                side_reg <= side_w[k];
            end
        end

        assign rem_w[k+1]  = rem_reg;
        assign den_w[k+1]  = den_reg;
        assign quo_w[k+1]  = quo_reg;
        assign side_w[k+1] = side_reg;
        assign val_w[k+1]  = valid_reg;
    end

    assign out_valid = val_w[STEPS];
    assign quo       = quo_w[STEPS];
    assign side_out  = side_w[STEPS];

endmodule

`default_nettype wire

### hw/rtl/gbfi_back.sv
// ----------------------------------------------------------------------------
// gbfi_back
// Step size from the weight or half the C-to-D distance, then move the central value toward downwind or hold it.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfi_back #(
    parameter int VALUE_WIDTH = gbfi_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [gbfi_pkg::WEIGHT_BITS-1:0]    weight,
    input  wire logic [VALUE_WIDTH-1:0]              cen,
    input  wire logic [VALUE_WIDTH-1:0]              cdmag,
    input  wire gbfi_pkg::flags_t                    flags,
    output logic                                     out_valid,
    output logic [VALUE_WIDTH-1:0]                   face_value
);

    localparam int W  = VALUE_WIDTH;
    localparam int WB = gbfi_pkg::WEIGHT_BITS;

    logic [W+WB-1:0]  prod;
    logic [W-1:0]     delta_next;
    logic [W-1:0]     res_next;

    logic             valid_a_reg, valid_b_reg;
    logic [W-1:0]     delta_reg, cen_reg, res_reg;
    gbfi_pkg::flags_t flags_reg;

    // Scale the C-to-D distance by the weight, or halve it
    assign prod       = (W+WB)'(cdmag) * (W+WB)'(weight);
    assign delta_next = flags.ge ? (cdmag >> 1)
                                 : W'(prod >> gbfi_pkg::PHI_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delta_reg <= delta_next;
            cen_reg   <= cen;
            flags_reg <= flags;
        end
    end

    // Move C toward D, or hold C when phi is outside (0,1)
    always_comb begin
        if (!flags_reg.take) begin
            res_next = cen_reg;
        end else if (flags_reg.cdneg) begin
            res_next = cen_reg - delta_reg;
        end else begin
            res_next = cen_reg + delta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = valid_b_reg;
    assign face_value = res_reg;

endmodule

`default_nettype wire
